// ----- rtl/lpprf_pkg.sv -----
// shared types and constants for the length-prefixed packet ring fifo
package lpprf_pkg;

   // default store size in bytes
   localparam int BUFFER_BYTES_DEFAULT = 4096;

   // header layout: little-endian length word, then little-endian timestamp
   localparam int LENGTH_BYTES = 4;
   localparam int STAMP_BYTES  = 8;
   localparam int HEADER_BYTES = LENGTH_BYTES + STAMP_BYTES;

   typedef logic [3:0] hdr_idx_type;

   typedef enum logic [1:0] {
      CMD_WR_BEGIN = 2'd0,
      CMD_WR_BYTE  = 2'd1,
      CMD_RD_BEGIN = 2'd2,
      CMD_RD_BYTE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_ROOM = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_FLUSHED = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     command;
      logic [11:0] payload_length;
      logic [62:0] time_stamp;
      logic [7:0]  write_data;
      logic [12:0] read_limit;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] packet_length;
      logic [7:0]  read_data;
      logic        last_byte;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic        latch_req;
      logic        wr_open;
      logic        hdr_write;
      logic        byte_write;
      logic        hdr_read;
      logic        rd_open;
      logic        byte_read;
      logic        finish;
      logic        flush;
      hdr_idx_type hdr_index;
      logic        rsp_load;
      status_type  rsp_status;
      logic        rsp_pkt_len;
      logic        rsp_rdata;
      logic        rsp_last;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic write_open;
      logic write_last;
      logic read_open;
      logic no_room;
      logic readable_zero;
      logic readable_over;
      logic word_bad;
      logic word_zero;
      logic credit_bad;
      logic plen_zero;
   } dp_stat_type;

endpackage

// ----- rtl/lpprf_req_if.sv -----
// request channel interface: valid, ready and request payload
interface lpprf_req_if;
   logic                        valid;
   logic                        ready;
   lpprf_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/lpprf_rsp_if.sv -----
// response channel interface: valid, ready and response payload
interface lpprf_rsp_if;
   logic                        valid;
   logic                        ready;
   lpprf_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/lpprf_ram.sv -----
// generic single-port ram with registered read
module lpprf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lpprf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one access per cycle, read data registered
   always_ff @(posedge clock) begin
      if (write_enable) begin
         store_ff[address] <= write_data;
      end else begin
         rdata_ff <= store_ff[address];
      end
   end

   assign read_data = rdata_ff;

endmodule

// ----- rtl/lpprf_ctrl.sv -----
// controller state machine: sequences header, byte and check steps
module lpprf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  lpprf_pkg::cmd_type      req_command,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  lpprf_pkg::dp_stat_type  stat,
   output lpprf_pkg::dp_cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_WR_HDR   = 5'b00010,
      S_RD_HDR   = 5'b00100,
      S_RD_CHECK = 5'b01000,
      S_RD_DATA  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   lpprf_pkg::hdr_idx_type  cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept;

   // take a transaction only when idle and the output register frees up
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = lpprf_pkg::ST_IGNORED;
      cmd.hdr_index  = cnt_ff;
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               case (req_command)
                  lpprf_pkg::CMD_WR_BEGIN: begin
                     if (stat.write_open) begin
                        cmd.rsp_load = 1'b1;
                     end else if (stat.no_room) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = lpprf_pkg::ST_NO_ROOM;
                     end else begin
                        cmd.wr_open = 1'b1;
                        cnt_in      = '0;
                        state_in    = S_WR_HDR;
                     end
                  end
                  lpprf_pkg::CMD_WR_BYTE: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.write_open) begin
                        cmd.byte_write = 1'b1;
                        cmd.rsp_status = lpprf_pkg::ST_OK;
                        cmd.rsp_last   = stat.write_last;
                     end
                  end
                  lpprf_pkg::CMD_RD_BEGIN: begin
                     if (stat.read_open) begin
                        cmd.rsp_load = 1'b1;
                     end else if (stat.readable_zero) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = lpprf_pkg::ST_EMPTY;
                     end else if (stat.readable_over) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.flush      = 1'b1;
                        cmd.rsp_status = lpprf_pkg::ST_FLUSHED;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_RD_HDR;
                     end
                  end
                  lpprf_pkg::CMD_RD_BYTE: begin
                     if (stat.read_open) begin
                        cmd.byte_read = 1'b1;
                        state_in      = S_RD_DATA;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         // write the twelve header bytes
         S_WR_HDR: begin
            cmd.hdr_write = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == 4'(lpprf_pkg::HEADER_BYTES - 1)) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = lpprf_pkg::ST_OK;
               cmd.rsp_last   = stat.plen_zero;
               state_in       = S_IDLE;
            end
         end
         // fetch the four length bytes
         S_RD_HDR: begin
            cmd.hdr_read = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 4'(lpprf_pkg::LENGTH_BYTES - 1)) begin
               state_in = S_RD_CHECK;
            end
         end
         // check the length word, then open the read or flush the store
         S_RD_CHECK: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
            if (stat.word_bad) begin
               cmd.flush      = 1'b1;
               cmd.rsp_status = lpprf_pkg::ST_FLUSHED;
            end else begin
               cmd.rd_open     = 1'b1;
               cmd.rsp_status  = lpprf_pkg::ST_OK;
               cmd.rsp_pkt_len = 1'b1;
               if (stat.word_zero) begin
                  cmd.rsp_last = 1'b1;
                  cmd.finish   = 1'b1;
                  if (stat.credit_bad) begin
                     cmd.flush      = 1'b1;
                     cmd.rsp_status = lpprf_pkg::ST_FLUSHED;
                  end
               end
            end
         end
         // body byte arrives from the store
         S_RD_DATA: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_rdata  = 1'b1;
            cmd.rsp_status = lpprf_pkg::ST_OK;
            state_in       = S_IDLE;
            if (!stat.read_open) begin
               cmd.rsp_last = 1'b1;
               cmd.finish   = 1'b1;
               if (stat.credit_bad) begin
                  cmd.flush      = 1'b1;
                  cmd.rsp_status = lpprf_pkg::ST_FLUSHED;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output valid holds until the receiver takes the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/lpprf_dp.sv -----
// datapath: positions, space counters, header assembly and the byte store
module lpprf_dp #(
   parameter int BUFFER_BYTES = lpprf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpprf_pkg::req_payload_type  req_payload,
   input  lpprf_pkg::dp_cmd_type       cmd,
   output lpprf_pkg::dp_stat_type      stat,
   output lpprf_pkg::rsp_payload_type  rsp_payload
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = AW + 1;
   localparam int WW = ((CW > 13) ? CW : 13) + 1;

   // position and space registers
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] readable_ff, readable_in;
   logic [CW-1:0] wr_left_ff, wr_left_in, rd_left_ff, rd_left_in;
   logic [CW-1:0] wr_total_ff, wr_total_in, rd_total_ff, rd_total_in;

   // latched request fields and length word bytes
   logic [62:0]      stamp_ff, stamp_in;
   logic [11:0]      plen_ff, plen_in;
   logic [12:0]      limit_ff, limit_in;
   logic [2:0][7:0]  word_ff, word_in;
   lpprf_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [AW-1:0]     wp_inc, rp_inc, ram_addr;
   logic              ram_we;
   logic [7:0]        ram_wdata, ram_rdata;
   logic [12:0]       hdr_word;
   logic [11:0][7:0]  hdr_bytes;
   logic [31:0]       word_full;
   logic [CW-1:0]     word_total, fin_amt, readable_sub;
   logic [WW-1:0]     need_room;

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos);
      next_pos = (pos == AW'(BUFFER_BYTES - 1)) ? '0 : pos + 1'b1;
   endfunction

   assign wp_inc = next_pos(wp_ff);
   assign rp_inc = next_pos(rp_ff);

   // header image: length word then timestamp, little-endian
   assign hdr_word  = 13'(plen_ff) + 13'(lpprf_pkg::STAMP_BYTES);
   assign hdr_bytes = {1'b0, stamp_ff, 19'd0, hdr_word};

   // store port: writes at the write position, reads at the read position
   assign ram_we    = cmd.hdr_write || cmd.byte_write;
   assign ram_addr  = ram_we ? wp_ff : rp_ff;
   assign ram_wdata = cmd.hdr_write ? hdr_bytes[cmd.hdr_index] : req_payload.write_data;

   lpprf_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   (ram_wdata),
      .read_data    (ram_rdata)
   );

   // room and length word checks
   assign need_room  = WW'(req_payload.payload_length) + WW'(lpprf_pkg::HEADER_BYTES);
   assign word_full  = {ram_rdata, word_ff};
   assign word_total = word_full[CW-1:0] + CW'(lpprf_pkg::LENGTH_BYTES);
   assign fin_amt    = cmd.rd_open ? word_total : rd_total_ff;
   assign readable_sub = (readable_ff >= fin_amt) ? readable_ff - fin_amt : '0;

   always_comb begin
      stat.write_open    = (wr_left_ff != '0);
      stat.write_last    = (wr_left_ff == CW'(1));
      stat.read_open     = (rd_left_ff != '0);
      stat.no_room       = (WW'(free_ff) < need_room);
      stat.readable_zero = (readable_ff == '0);
      stat.readable_over = (readable_ff > CW'(BUFFER_BYTES));
      stat.word_bad      = (({1'b0, word_full} + 33'(lpprf_pkg::LENGTH_BYTES))
                            > 33'(readable_ff)) || (word_full > 32'(limit_ff));
      stat.word_zero     = (word_full == '0);
      stat.credit_bad    = (free_ff > CW'(BUFFER_BYTES)) ||
                           (({1'b0, free_ff} + {1'b0, fin_amt}) > (CW+1)'(BUFFER_BYTES));
      stat.plen_zero     = (plen_ff == '0);
   end

   // register updates, flush has the last word
   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      free_in     = free_ff;
      readable_in = readable_ff;
      wr_left_in  = wr_left_ff;
      rd_left_in  = rd_left_ff;
      wr_total_in = wr_total_ff;
      rd_total_in = rd_total_ff;
      stamp_in    = stamp_ff;
      plen_in     = plen_ff;
      limit_in    = limit_ff;
      word_in     = word_ff;
      rsp_in      = rsp_ff;

      if (cmd.latch_req) begin
         stamp_in = req_payload.time_stamp;
         plen_in  = req_payload.payload_length;
         limit_in = req_payload.read_limit;
      end

      // reserve room for header and payload
      if (cmd.wr_open) begin
         free_in    = free_ff - CW'(need_room);
         wr_left_in = CW'(req_payload.payload_length);
         if (req_payload.payload_length == '0) begin
            readable_in = readable_ff + CW'(need_room);
            wr_total_in = '0;
         end else begin
            wr_total_in = CW'(need_room);
         end
      end

      if (ram_we) begin
         wp_in = wp_inc;
      end

      // payload byte, packet goes readable after the last one
      if (cmd.byte_write) begin
         wr_left_in = wr_left_ff - 1'b1;
         if (wr_left_ff == CW'(1)) begin
            readable_in = readable_ff + wr_total_ff;
            wr_total_in = '0;
         end
      end

      // length bytes land in the cycle after their read
      if (cmd.hdr_read) begin
         rp_in = rp_inc;
         if (cmd.hdr_index != '0) begin
            word_in[2'(cmd.hdr_index - 1'b1)] = ram_rdata;
         end
      end

      if (cmd.rd_open) begin
         rd_total_in = word_total;
         rd_left_in  = word_full[CW-1:0];
      end

      if (cmd.byte_read) begin
         rp_in      = rp_inc;
         rd_left_in = rd_left_ff - 1'b1;
      end

      // give the packet space back
      if (cmd.finish) begin
         readable_in = readable_sub;
         free_in     = free_ff + fin_amt;
         rd_total_in = '0;
      end

      if (cmd.flush) begin
         rp_in       = wp_ff;
         free_in     = CW'(BUFFER_BYTES);
         readable_in = '0;
         wr_left_in  = '0;
         rd_left_in  = '0;
         wr_total_in = '0;
         rd_total_in = '0;
      end

      // response transaction
      if (cmd.rsp_load) begin
         rsp_in.status        = cmd.rsp_status;
         rsp_in.packet_length = cmd.rsp_pkt_len ? word_full[11:0] : '0;
         rsp_in.read_data     = cmd.rsp_rdata ? ram_rdata : '0;
         rsp_in.last_byte     = cmd.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         free_ff     <= CW'(BUFFER_BYTES);
         readable_ff <= '0;
         wr_left_ff  <= '0;
         rd_left_ff  <= '0;
         wr_total_ff <= '0;
         rd_total_ff <= '0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         free_ff     <= free_in;
         readable_ff <= readable_in;
         wr_left_ff  <= wr_left_in;
         rd_left_ff  <= rd_left_in;
         wr_total_ff <= wr_total_in;
         rd_total_ff <= rd_total_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      plen_ff  <= plen_in;
      limit_ff <= limit_in;
      word_ff  <= word_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/length_prefixed_packet_ring_fifo_unit.sv -----
// Length-prefixed packet ring fifo: a byte-wide circular packet store.
// req_if carries one command per transaction: write begin (length and
// timestamp), write payload byte, read begin (with the reader's limit) and
// read next byte. rsp_if returns exactly one response transaction for each
// request: status, body length at read begin, body byte and last-byte flag.
// Steps per request, from acceptance until its response is loaded:
//   write payload byte, rejected or ignored requests: loaded at acceptance
//   read next byte: a registered read of the byte store
//   read begin: four length-byte reads, then the length check
//   write begin: twelve header bytes through the single store port
// The single-port byte store sets these steps: one byte moves per cycle.
// The response sits in an output register; a new request is taken in the
// cycle that register is emptied, so back-to-back byte writes run at one
// per cycle. A stalled receiver holds the response and blocks new requests.
// Reset (synchronous) empties the store logically: positions zero, all space
// free, no open packet. The byte store itself is not cleared; no entry is
// read before it is written.
module length_prefixed_packet_ring_fifo_unit #(
   parameter int BUFFER_BYTES = lpprf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lpprf_req_if.sink    req_if,
   lpprf_rsp_if.source  rsp_if
);

   lpprf_pkg::dp_cmd_type   cmd;
   lpprf_pkg::dp_stat_type  stat;

   lpprf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.payload.command),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   lpprf_dp #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_if.payload)
   );

endmodule
